/* hdl/rcn_pkg.sv */
// Shared types and constants for the normalized 3x3 RGB convolution core.
// No dependencies; the core module refers to it by scoped names.
package rcn_pkg;

    localparam int DIM_W   = 11;   // width / height register width
    localparam int COEF_W  = 24;   // one kernel row, three signed bytes
    localparam int PIX_W   = 24;   // blue, green, red
    localparam int SUM_W   = 20;   // signed channel sum over nine taps
    localparam int CSUM_W  = 12;   // signed coefficient sum
    localparam int DIV_D   = 12;   // divisor width of the shared divider
    localparam int IDX_W   = 3;    // configuration register index width

    localparam logic [IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_TOP    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MID    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_BOTTOM = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KDIV,
        ST_RD,
        ST_WR,
        ST_MAC,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } state_t;

endpackage

/* hdl/rcn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/rcn_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by position and normalization divides.
module rcn_div #(
    parameter int N = 21,
    parameter int D = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient,
    output logic [D-1:0] remainder
);
    localparam int CW = $clog2(N + 1);

    logic [D:0]    rem_reg, rem_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [D:0]    trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[D-1:0], quo_reg[N-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[D-1:0];
endmodule

/* hdl/rgb_conv3x3_normalized_core.sv */
// Normalized 3x3 RGB convolution core: sequencer, line stores, window, MAC.
// Depends on rcn_pkg, rcn_ram and rcn_div.
//
// Usage:
//   s_ channel: one raster-order pixel per item, s_tdata = blue, green, red;
//   s_tuser flags a flush item. After width*height pixels send width+1
//   flush items. Each result trails its input by width+1 items.
//   m_ channel: filtered blue, green, red in m_tdata, m_tlast on the last
//   pixel of the frame. Items that fall before the window fills give none.
//   cfg_ channel: register index and data, always ready; write between items.
// Throughput: one item at a time. An item runs the column divide and the line
//   store access; a producing item adds a MAC step for each of the nine taps,
//   up to three normalization divides through the one shared divider and an
//   output step.
// Stalls: a finished result sits in the output register while the next
//   item is accepted; the core waits only if a second result is ready first.
// Reset: registers return to width 1, height 1, identity kernel; the
//   frame count and window clear; line store contents stay undefined.
module rgb_conv3x3_normalized_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // in_blue, in_green, in_red
    input  logic                      s_tuser,   // filler
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // out_blue, out_green, out_red
    output logic                      m_tlast,   // frame_end
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rcn_pkg::IDX_W-1:0] cfg_index,
    input  logic [23:0]               cfg_data
);
    localparam int DW    = rcn_pkg::DIM_W;
    localparam int W_CAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int H_CAP = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;
    localparam int CNT_W = $clog2(W_CAP * H_CAP + W_CAP + 1);
    localparam int CW    = CNT_W + 1;
    localparam int DIV_N = (CNT_W > rcn_pkg::SUM_W) ? CNT_W : rcn_pkg::SUM_W;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int SW    = rcn_pkg::SUM_W;

    rcn_pkg::state_t state_reg, state_next;

    logic [DW-1:0] width_reg, height_reg;
    logic [23:0]   ctop_reg, cmid_reg, cbot_reg;
    logic [DW-1:0] w_eff, h_eff;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [23:0]      x_reg, x_next;
    logic [DIV_N-1:0] q_reg, q_next;
    logic [DW-1:0]    col_reg, col_next;
    logic [DW-1:0]    r_reg, r_next, c_reg, c_next;
    logic             fend_reg, fend_next;
    logic [23:0]      win_reg [9];
    logic [23:0]      win_next [9];
    logic [1:0]       mi_reg, mi_next, mj_reg, mj_next;
    logic [1:0]       ch_reg, ch_next;
    logic signed [SW-1:0]                sum_reg [3];
    logic signed [SW-1:0]                sum_next [3];
    logic signed [rcn_pkg::CSUM_W-1:0]   csum_reg, csum_next;
    logic [7:0]       res_reg [3];
    logic [7:0]       res_next [3];
    logic             mval_reg, mval_next;
    logic [23:0]      mdata_reg, mdata_next;
    logic             mlast_reg, mlast_next;

    logic             div_start, div_done;
    logic [DIV_N-1:0] div_dividend, div_quot;
    logic [rcn_pkg::DIV_D-1:0] div_divisor, div_rem;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [23:0]   top_rd, mid_rd;

    logic [CW-1:0] kk, wp1, pos;
    logic          produce;
    logic [3:0]    tidx;
    logic [23:0]   tap, crow;
    logic signed [7:0]  cf;
    logic          inb;
    logic signed [16:0] prod [3];
    logic signed [SW-1:0] cur_sum, abs_sum;
    logic [rcn_pkg::CSUM_W-1:0] abs_csum;
    logic [7:0]    qlow;

    // effective sizes: zero reads as one, large values saturate
    assign w_eff = (width_reg == '0) ? DW'(1) :
                   ({1'b0, width_reg} > (DW+1)'(W_CAP)) ? DW'(W_CAP) : width_reg;
    assign h_eff = (height_reg == '0) ? DW'(1) :
                   ({1'b0, height_reg} > (DW+1)'(H_CAP)) ? DW'(H_CAP) : height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DW'(1);
            height_reg <= DW'(1);
            ctop_reg   <= 24'h000000;
            cmid_reg   <= 24'h000100;
            cbot_reg   <= 24'h000000;
        end else if (cfg_valid) begin
            case (cfg_index)
                rcn_pkg::CFG_WIDTH:  width_reg  <= cfg_data[DW-1:0];
                rcn_pkg::CFG_HEIGHT: height_reg <= cfg_data[DW-1:0];
                rcn_pkg::CFG_TOP:    ctop_reg   <= cfg_data;
                rcn_pkg::CFG_MID:    cmid_reg   <= cfg_data;
                rcn_pkg::CFG_BOTTOM: cbot_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    rcn_div #(.N(DIV_N), .D(rcn_pkg::DIV_D)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign ram_addr = AW'(col_reg);

    rcn_ram #(.WIDTH(rcn_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_top_line (
        .aclk (aclk), .we (ram_we), .waddr (ram_addr), .wdata (mid_rd),
        .raddr (ram_addr), .rdata (top_rd)
    );

    rcn_ram #(.WIDTH(rcn_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_mid_line (
        .aclk (aclk), .we (ram_we), .waddr (ram_addr), .wdata (x_reg),
        .raddr (ram_addr), .rdata (mid_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcn_pkg::ST_IDLE;
            count_reg <= '0;
            mval_reg  <= 1'b0;
            for (int t = 0; t < 9; t++) begin
                win_reg[t] <= '0;
            end
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mval_reg  <= mval_next;
            for (int t = 0; t < 9; t++) begin
                win_reg[t] <= win_next[t];
            end
        end
        k_reg     <= k_next;
        total_reg <= total_next;
        x_reg     <= x_next;
        q_reg     <= q_next;
        col_reg   <= col_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        fend_reg  <= fend_next;
        mi_reg    <= mi_next;
        mj_reg    <= mj_next;
        ch_reg    <= ch_next;
        csum_reg  <= csum_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        for (int t = 0; t < 3; t++) begin
            sum_reg[t] <= sum_next[t];
            res_reg[t] <= res_next[t];
        end
    end

    // tap and coefficient of the current MAC step
    assign tidx = 4'(mi_reg) * 4'd3 + 4'(mj_reg);
    assign tap  = win_reg[tidx];
    assign crow = (mi_reg == 2'd0) ? ctop_reg : (mi_reg == 2'd1) ? cmid_reg : cbot_reg;
    assign cf   = $signed(crow[8*mj_reg +: 8]);
    assign inb  = !(mi_reg == 2'd0 && r_reg == '0)
               && !(mi_reg == 2'd2 && ({1'b0, r_reg} + 1'b1) >= {1'b0, h_eff})
               && !(mj_reg == 2'd0 && c_reg == '0)
               && !(mj_reg == 2'd2 && ({1'b0, c_reg} + 1'b1) >= {1'b0, w_eff});

    always_comb begin
        for (int t = 0; t < 3; t++) begin
            prod[t] = $signed({1'b0, tap[8*t +: 8]}) * cf;
        end
    end

    assign kk      = CW'(k_reg);
    assign wp1     = CW'(w_eff) + CW'(1);
    assign pos     = kk - wp1;
    assign produce = (kk >= wp1) && (pos < CW'(total_reg));

    assign cur_sum  = sum_reg[ch_reg];
    assign abs_sum  = cur_sum[SW-1] ? -cur_sum : cur_sum;
    assign abs_csum = csum_reg[rcn_pkg::CSUM_W-1] ? -csum_reg : csum_reg;
    assign qlow     = (cur_sum[SW-1] ^ csum_reg[rcn_pkg::CSUM_W-1]) ?
                      (~div_quot[7:0] + 8'd1) : div_quot[7:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        total_next = total_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        col_next   = col_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        fend_next  = fend_reg;
        mi_next    = mi_reg;
        mj_next    = mj_reg;
        ch_next    = ch_reg;
        csum_next  = csum_reg;
        mdata_next = mdata_reg;
        mlast_next = mlast_reg;
        mval_next  = mval_reg && !m_tready;
        for (int t = 0; t < 9; t++) begin
            win_next[t] = win_reg[t];
        end
        for (int t = 0; t < 3; t++) begin
            sum_next[t] = sum_reg[t];
            res_next[t] = res_reg[t];
        end
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_N'(count_reg);
        div_divisor  = rcn_pkg::DIV_D'(w_eff);
        ram_we       = 1'b0;

        case (state_reg)
            rcn_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    x_next     = s_tdata;
                    k_next     = count_reg;
                    total_next = CNT_W'({{DW{1'b0}}, w_eff} * {{DW{1'b0}}, h_eff});
                    div_start  = 1'b1;
                    state_next = rcn_pkg::ST_KDIV;
                end
            end
            rcn_pkg::ST_KDIV: begin
                if (div_done) begin
                    q_next     = div_quot;
                    col_next   = DW'(div_rem);
                    state_next = rcn_pkg::ST_RD;
                end
            end
            rcn_pkg::ST_RD: begin
                state_next = rcn_pkg::ST_WR;
            end
            rcn_pkg::ST_WR: begin
                ram_we = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    win_next[i*3]     = win_reg[i*3 + 1];
                    win_next[i*3 + 1] = win_reg[i*3 + 2];
                end
                win_next[2] = top_rd;
                win_next[5] = mid_rd;
                win_next[8] = x_reg;
                // window center sits one row and one column behind the input
                r_next = DW'(q_reg - ((col_reg != '0) ? DIV_N'(1) : DIV_N'(2)));
                c_next = (col_reg != '0) ? col_reg - 1'b1 : w_eff - 1'b1;
                fend_next = (pos == CW'(total_reg) - CW'(1));
                count_next = (kk >= CW'(total_reg) + CW'(w_eff)) ? '0 : count_reg + 1'b1;
                mi_next   = 2'd0;
                mj_next   = 2'd0;
                csum_next = '0;
                for (int t = 0; t < 3; t++) begin
                    sum_next[t] = '0;
                end
                state_next = produce ? rcn_pkg::ST_MAC : rcn_pkg::ST_IDLE;
            end
            rcn_pkg::ST_MAC: begin
                if (inb) begin
                    csum_next = csum_reg + rcn_pkg::CSUM_W'(cf);
                    for (int t = 0; t < 3; t++) begin
                        sum_next[t] = sum_reg[t] + SW'(prod[t]);
                    end
                end
                if (mj_reg == 2'd2) begin
                    mj_next = 2'd0;
                    mi_next = mi_reg + 1'b1;
                    if (mi_reg == 2'd2) begin
                        ch_next    = 2'd0;
                        state_next = rcn_pkg::ST_DSTART;
                    end
                end else begin
                    mj_next = mj_reg + 1'b1;
                end
            end
            rcn_pkg::ST_DSTART: begin
                if (csum_reg == '0) begin
                    // zero coefficient sum: keep the raw sum
                    res_next[ch_reg] = cur_sum[7:0];
                    ch_next    = ch_reg + 1'b1;
                    state_next = (ch_reg == 2'd2) ? rcn_pkg::ST_OUT : rcn_pkg::ST_DSTART;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DIV_N'(abs_sum);
                    div_divisor  = rcn_pkg::DIV_D'(abs_csum);
                    state_next   = rcn_pkg::ST_DWAIT;
                end
            end
            rcn_pkg::ST_DWAIT: begin
                if (div_done) begin
                    res_next[ch_reg] = qlow;
                    ch_next    = ch_reg + 1'b1;
                    state_next = (ch_reg == 2'd2) ? rcn_pkg::ST_OUT : rcn_pkg::ST_DSTART;
                end
            end
            rcn_pkg::ST_OUT: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdata_next = {res_reg[2], res_reg[1], res_reg[0]};
                    mlast_next = fend_reg;
                    state_next = rcn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rcn_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    // s_tuser marks flush items; position alone decides masking
    logic unused_filler;
    assign unused_filler = s_tuser;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == rcn_pkg::ST_KDIV || state_reg == rcn_pkg::ST_DWAIT))
        else $error("divider finished with no waiting state");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == rcn_pkg::ST_OUT))
        else $error("result raised outside output state");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result overwritten");
endmodule
